/* rtl/irpcr_pkg.sv */
package irpcr_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SEG_LIMIT   = ((STORE_DEPTH - 1) < 254) ? (STORE_DEPTH - 1) : 254;

  localparam logic [7:0] SEG_FULL      = 8'd255;
  localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_READ  = 3'd1,
    OP_CLEAR = 3'd2,
    OP_WRITE = 3'd3,
    OP_START = 3'd4
  } op_e;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] capture_count;
    logic       captured;
    logic       capturing;
    logic       playing;
    logic       carrier_out;
  } result_t;

endpackage

/* rtl/ir_pulse_capture_replay.sv */
// Infrared learn and replay block. One request (a tick, a capture read, a capture clear, a
// play-store write or a playback start) is taken every clock cycle unless in_stall_o is high;
// its status result is registered in a result stage with the registered capture-memory read,
// then held in a two-entry output queue; requests stall while that queue would be full.
// Capture and play stores are single-port-write memories; the capture store is emptied at
// once by per-entry valid flags, so there is no clearing pass after reset. Play entries are
// consumed by playback and must be written again before a replay.
module ir_pulse_capture_replay
  import irpcr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] op_i,
  input  logic       pin_level_i,
  input  logic [7:0] entry_index_i,
  input  logic [7:0] entry_value_i,
  input  logic [7:0] play_length_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [7:0] capture_count_o,
  output logic       captured_o,
  output logic       capturing_o,
  output logic       playing_o,
  output logic       carrier_out_o
);

  logic                   trig_q;
  logic [7:0]             seg_q, seg_d;
  logic [7:0]             cnt_q, cnt_d;
  logic [1:0]             last_q, last_d;
  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic                   play_q, play_d;
  logic [7:0]             pos_q, pos_d;
  logic [7:0]             len_q, len_d;
  logic                   out_q, out_d;
  logic [7:0]             pcur_q, pcur_d;
  logic                   psel_q, psel_d;
  logic [STORE_DEPTH-1:0] cvalid_q;

  logic                   in_acc;
  logic                   idx_ok;
  logic                   cap_clr;
  logic                   cap_we;
  logic [ADDR_W-1:0]      cap_waddr;
  logic                   cap_re;
  logic [7:0]             cap_rdata;
  logic                   pl_we;
  logic [ADDR_W-1:0]      pl_waddr;
  logic [7:0]             pl_wdata;
  logic                   pl_re;
  logic [ADDR_W-1:0]      pl_raddr;
  logic [7:0]             pl_rdata;
  logic [7:0]             pval;
  logic [7:0]             pos_nx;

  logic                   s1_valid_q;
  logic                   s1_rd_q;
  result_t                s1_res_q;
  result_t                fifo_q [2];
  logic                   wptr_q, rptr_q;
  logic [1:0]             fcnt_q;
  logic                   push, pop;
  logic [2:0]             occ;
  result_t                push_item;

  assign in_acc = in_valid_i && !in_stall_o;
  assign idx_ok = {1'b0, entry_index_i} < 9'(STORE_DEPTH);
  assign pval   = psel_q ? pcur_q : pl_rdata;
  assign pos_nx = pos_q + 8'd1;
  assign cap_re = in_acc && (op_i == OP_READ);

  always_comb begin
    logic [7:0] seg_t;
    logic [7:0] cnt_t;
    seg_t     = seg_q;
    cnt_t     = cnt_q;
    seg_d     = seg_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    run_d     = run_q;
    done_d    = done_q;
    play_d    = play_q;
    pos_d     = pos_q;
    len_d     = len_q;
    out_d     = out_q;
    pcur_d    = pcur_q;
    psel_d    = psel_q;
    cap_clr   = 1'b0;
    cap_we    = 1'b0;
    cap_waddr = seg_q[ADDR_W-1:0];
    pl_we     = 1'b0;
    pl_waddr  = pos_q[ADDR_W-1:0];
    pl_wdata  = entry_value_i;
    pl_re     = 1'b0;
    pl_raddr  = pos_nx[ADDR_W-1:0];
    if (in_acc) begin
      unique case (op_i)
        OP_TICK: begin
          if (play_q) begin
            if (pos_q < len_q && {1'b0, pos_q} < 9'(STORE_DEPTH)) begin
              out_d = pos_q[0] ? 1'b0 : ~out_q;
              if (pval == 8'd0) begin
                pos_d  = pos_nx;
                pl_re  = 1'b1;
                psel_d = 1'b0;
              end else begin
                pcur_d   = pval - 8'd1;
                psel_d   = 1'b1;
                pl_we    = 1'b1;
                pl_wdata = pval - 8'd1;
              end
            end else begin
              play_d = 1'b0;
              run_d  = 1'b0;
              out_d  = 1'b0;
            end
          end else if (run_q || pin_level_i == trig_q) begin
            run_d = 1'b1;
            if ({1'b0, pin_level_i} != last_q) begin
              last_d = {1'b0, pin_level_i};
              if (seg_q < 8'(SEG_LIMIT)) begin
                seg_t = seg_q + 8'd1;
                cnt_t = 8'd0;
              end
            end
            if (cnt_t < SEG_FULL) begin
              cnt_t  = cnt_t + 8'd1;
              cap_we = 1'b1;
            end else if (seg_t != 8'd0) begin
              done_d = 1'b1;
              run_d  = 1'b0;
            end
            seg_d     = seg_t;
            cnt_d     = cnt_t;
            cap_waddr = seg_t[ADDR_W-1:0];
          end
        end
        OP_READ: begin
        end
        OP_CLEAR: begin
          cap_clr = 1'b1;
          if (play_q) begin
            run_d = 1'b0;
          end
          play_d = 1'b0;
          len_d  = 8'd0;
          pos_d  = 8'd0;
          seg_d  = 8'd0;
          cnt_d  = 8'd0;
          done_d = 1'b0;
          last_d = LEVEL_UNKNOWN;
          out_d  = 1'b0;
        end
        OP_WRITE: begin
          if (idx_ok) begin
            pl_we    = 1'b1;
            pl_waddr = entry_index_i[ADDR_W-1:0];
            if (entry_index_i == pos_q) begin
              pcur_d = entry_value_i;
              psel_d = 1'b1;
            end
          end
        end
        OP_START: begin
          play_d   = 1'b1;
          len_d    = play_length_i;
          pos_d    = 8'd0;
          run_d    = 1'b0;
          pl_re    = 1'b1;
          pl_raddr = '0;
          psel_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  irpcr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_cap_ram (
    .clk_i  (clk_i),
    .we_i   (cap_we),
    .waddr_i(cap_waddr),
    .wdata_i(cnt_d),
    .re_i   (cap_re),
    .raddr_i(entry_index_i[ADDR_W-1:0]),
    .rdata_o(cap_rdata)
  );

  irpcr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_play_ram (
    .clk_i  (clk_i),
    .we_i   (pl_we),
    .waddr_i(pl_waddr),
    .wdata_i(pl_wdata),
    .re_i   (pl_re),
    .raddr_i(pl_raddr),
    .rdata_o(pl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q   <= 1'b0;
      seg_q    <= 8'd0;
      cnt_q    <= 8'd0;
      last_q   <= LEVEL_UNKNOWN;
      run_q    <= 1'b0;
      done_q   <= 1'b0;
      play_q   <= 1'b0;
      pos_q    <= 8'd0;
      len_q    <= 8'd0;
      out_q    <= 1'b0;
      pcur_q   <= 8'd0;
      psel_q   <= 1'b1;
      cvalid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        trig_q <= cfg_wdata_i;
      end
      seg_q  <= seg_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
      run_q  <= run_d;
      done_q <= done_d;
      play_q <= play_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      out_q  <= out_d;
      pcur_q <= pcur_d;
      psel_q <= psel_d;
      if (cap_clr) begin
        cvalid_q <= '0;
      end else if (cap_we) begin
        cvalid_q[cap_waddr] <= 1'b1;
      end
    end
  end

  // Result stage: status after the request, capture read resolved next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_rd_q                <= cap_re && idx_ok && cvalid_q[entry_index_i[ADDR_W-1:0]];
      s1_res_q.read_data     <= 8'd0;
      s1_res_q.capture_count <= seg_d;
      s1_res_q.captured      <= done_d;
      s1_res_q.capturing     <= run_d && !play_d;
      s1_res_q.playing       <= play_d;
      s1_res_q.carrier_out   <= out_d;
    end
  end

  always_comb begin
    push_item           = s1_res_q;
    push_item.read_data = s1_rd_q ? cap_rdata : 8'd0;
  end

  assign push       = s1_valid_q;
  assign pop        = out_valid_o && !out_stall_i;
  assign occ        = {1'b0, fcnt_q} + {2'b00, s1_valid_q} - {2'b00, pop};
  assign in_stall_o = occ >= 3'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fcnt_q <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= push_item;
    end
  end

  assign out_valid_o     = fcnt_q != 2'd0;
  assign read_data_o     = fifo_q[rptr_q].read_data;
  assign capture_count_o = fifo_q[rptr_q].capture_count;
  assign captured_o      = fifo_q[rptr_q].captured;
  assign capturing_o     = fifo_q[rptr_q].capturing;
  assign playing_o       = fifo_q[rptr_q].playing;
  assign carrier_out_o   = fifo_q[rptr_q].carrier_out;

endmodule

/* rtl/irpcr_ram.sv */
module irpcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/irpcr_checker.sv */
module irpcr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic [7:0] capture_count_o,
  input logic       captured_o,
  input logic       capturing_o,
  input logic       playing_o,
  input logic       carrier_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(read_data_o) && $stable(capture_count_o))
    else $error("stalled result changed");

  a_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(capturing_o && playing_o))
    else $error("capture and playback both active");

  a_carrier_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !playing_o |-> !carrier_out_o)
    else $error("carrier driven outside playback");

  a_captured_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && captured_o |-> capture_count_o != 8'd0)
    else $error("capture ended at first segment");

endmodule

bind ir_pulse_capture_replay irpcr_checker u_checker (.*);
